// ===== src/stq_pkg.sv =====
package stq_pkg;
  localparam int SLOTS_DEF     = 16;
  localparam int TIME_BITS_DEF = 32;
  localparam int ID_W          = 4;
  localparam int TV_W          = 32;
  localparam int MAX_OUT       = 16;

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_MODIFY = 2'd2,
    MODE_TICK   = 2'd3
  } mode_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [3:0] timer_id;
    logic [31:0] time_value;
  } in_req_t;

  typedef struct packed {
    logic        expired_valid;
    logic [3:0]  expired_id;
    logic        was_pending;
    logic        head_changed;
    logic [31:0] next_expiry;
    logic        queue_empty;
    logic        last;
  } out_req_t;

  // controller -> datapath commands
  typedef struct packed {
    logic load;    // capture incoming request
    logic unlink;  // remove addressed slot from the row
    logic link;    // insert addressed slot into the row
    logic pop;     // remove head
  } stq_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic is_tick;
    logic is_delete;
    logic id_bad;
    logic head_due;
  } stq_sts_t;
endpackage

// ===== src/stq_if.sv =====
interface stq_in_if;
  import stq_pkg::*;
  logic    valid;
  logic    ready;
  in_req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface stq_out_if;
  import stq_pkg::*;
  logic     valid;
  logic     ready;
  out_req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/stq_datapath.sv =====
module stq_datapath #(
  parameter int SLOTS     = stq_pkg::SLOTS_DEF,
  parameter int TIME_BITS = stq_pkg::TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  stq_pkg::in_req_t     req,
  input  stq_pkg::stq_cmd_t    cmd,
  output stq_pkg::stq_sts_t    sts,
  output logic                 was_pending,
  output logic                 head_changed,
  output logic [3:0]           head_id,
  output logic [31:0]          next_expiry,
  output logic                 queue_empty,
  output logic [31:0]          fin_expiry,
  output logic                 fin_empty
);
  import stq_pkg::*;
  localparam int SW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  // sorted cell row: each cell holds a slot id and its expiry
  logic [SW-1:0]        cid_r   [SLOTS];
  logic [TIME_BITS-1:0] cexp_r  [SLOTS];
  logic [SLOTS-1:0]     pend_r;
  logic [CW-1:0]        cnt_r;
  logic [1:0]           mode_r;
  logic [3:0]           id_r;
  logic [TIME_BITS-1:0] t_r;
  logic                 wp_r, hc_r;

  logic [SW-1:0] sid;
  logic          bad;
  logic [SLOTS-1:0] occ, le, match, fh;

  assign bad = ({28'd0, id_r} >= 32'(SLOTS));
  assign sid = SW'(id_r);

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      occ[i]   = (CW'(i) < cnt_r);
      le[i]    = occ[i] && (cexp_r[i] <= t_r);
      match[i] = occ[i] && (cid_r[i] == sid);
    end
  end

  // head left once a tick has popped every due entry (at most MAX_OUT of them)
  always_comb begin
    fin_expiry = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (i < MAX_OUT)
        fh[i] = occ[i] && !le[i] && (i == 0 || le[(i == 0) ? 0 : i-1]);
      else if (i == MAX_OUT)
        fh[i] = occ[i] && le[(i == 0) ? 0 : i-1];
      else
        fh[i] = 1'b0;
      if (fh[i]) fin_expiry = fin_expiry | 32'(cexp_r[i]);
    end
    fin_empty = ~|fh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      cnt_r  <= '0;
      wp_r   <= 1'b0;
      hc_r   <= 1'b0;
    end else if (cmd.load) begin
      mode_r <= req.mode;
      id_r   <= req.timer_id;
      t_r    <= TIME_BITS'(req.time_value);
      wp_r   <= 1'b0;
      hc_r   <= 1'b0;
    end else if (cmd.unlink) begin
      if (!bad && pend_r[sid]) begin
        wp_r <= 1'b1;
        pend_r[sid] <= 1'b0;
        cnt_r <= cnt_r - 1'b1;
        for (int i = 0; i < SLOTS - 1; i++) begin
          if (|(match & ((SLOTS)'(2) << i) - 1'b1)) begin
            cid_r[i]  <= cid_r[i+1];
            cexp_r[i] <= cexp_r[i+1];
          end
        end
      end
    end else if (cmd.link) begin
      if (!bad && cnt_r < CW'(SLOTS)) begin
        pend_r[sid] <= 1'b1;
        cnt_r <= cnt_r + 1'b1;
        hc_r  <= !le[0];
        for (int i = 0; i < SLOTS; i++) begin
          if (!le[i] && (i == 0 || le[(i == 0) ? 0 : i-1])) begin
            cid_r[i]  <= sid;
            cexp_r[i] <= t_r;
          end else if (i > 0 && !le[(i == 0) ? 0 : i-1] && occ[(i == 0) ? 0 : i-1]) begin
            cid_r[i]  <= cid_r[(i == 0) ? 0 : i-1];
            cexp_r[i] <= cexp_r[(i == 0) ? 0 : i-1];
          end
        end
      end
    end else if (cmd.pop) begin
      pend_r[cid_r[0]] <= 1'b0;
      cnt_r <= cnt_r - 1'b1;
      for (int i = 0; i < SLOTS - 1; i++) begin
        cid_r[i]  <= cid_r[i+1];
        cexp_r[i] <= cexp_r[i+1];
      end
    end
  end

  assign sts.is_tick   = (mode_r == MODE_TICK);
  assign sts.is_delete = (mode_r == MODE_DELETE);
  assign sts.id_bad    = bad;
  assign sts.head_due  = le[0];
  assign was_pending   = wp_r;
  assign head_changed  = hc_r;
  assign head_id       = 4'(cid_r[0]);
  assign queue_empty   = (cnt_r == '0);
  assign next_expiry   = queue_empty ? 32'd0 : 32'(cexp_r[0]);
endmodule

// ===== src/stq_ctrl.sv =====
module stq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  stq_in_if.sink            in_ch,
  stq_out_if.source         out_ch,
  output stq_pkg::stq_cmd_t cmd,
  input  stq_pkg::stq_sts_t sts,
  input  logic              was_pending,
  input  logic              head_changed,
  input  logic [3:0]        head_id,
  input  logic [31:0]       next_expiry,
  input  logic              queue_empty,
  input  logic [31:0]       fin_expiry,
  input  logic              fin_empty
);
  import stq_pkg::*;
  typedef enum logic [2:0] {S_IDLE, S_UNLINK, S_LINK, S_TICK, S_EMIT, S_WAIT} state_t;
  state_t state_r, state_nxt;
  logic [4:0] n_r, n_nxt;
  logic [3:0] pid_r, pid_nxt;
  logic ov_r, ov_nxt;
  out_req_t od_r, od_nxt;
  logic [31:0] fx_r, fx_nxt;
  logic fe_r, fe_nxt;
  logic more;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = ov_r;
  assign out_ch.data  = od_r;
  assign more = sts.head_due && (n_r < 5'(MAX_OUT));

  always_comb begin
    state_nxt = state_r;
    n_nxt = n_r; pid_nxt = pid_r; ov_nxt = ov_r; od_nxt = od_r;
    fx_nxt = fx_r; fe_nxt = fe_r;
    cmd = '0;
    if (ov_r && out_ch.ready) ov_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: if (in_ch.valid) begin
        cmd.load = 1'b1;
        n_nxt = '0;
        state_nxt = (in_ch.data.mode == MODE_TICK) ? S_TICK : S_UNLINK;
      end
      S_UNLINK: begin
        cmd.unlink = 1'b1;
        state_nxt = (sts.is_delete || sts.id_bad) ? S_WAIT : S_LINK;
      end
      S_LINK: begin
        cmd.link = 1'b1;
        state_nxt = S_WAIT;
      end
      S_WAIT: if (!ov_r || out_ch.ready) begin
        ov_nxt = 1'b1;
        od_nxt = '{1'b0, 4'd0, was_pending, head_changed, next_expiry, queue_empty, 1'b1};
        state_nxt = S_IDLE;
      end
      S_TICK: begin
        // every result of a tick reports the list as it stands after all pops
        if (more) begin
          cmd.pop = 1'b1;
          pid_nxt = head_id;
          fx_nxt = fin_expiry;
          fe_nxt = fin_empty;
          n_nxt = n_r + 1'b1;
          state_nxt = S_EMIT;
        end else if (n_r == '0) begin
          if (!ov_r || out_ch.ready) begin
            ov_nxt = 1'b1;
            od_nxt = '{1'b0, 4'd0, 1'b0, 1'b0, next_expiry, queue_empty, 1'b1};
            state_nxt = S_IDLE;
          end
        end
      end
      S_EMIT: if (!ov_r || out_ch.ready) begin
        ov_nxt = 1'b1;
        od_nxt = '{1'b1, pid_r, 1'b0, 1'b0, fx_r, fe_r, !more};
        if (more) begin
          // next pop proceeds alongside this result
          cmd.pop = 1'b1;
          pid_nxt = head_id;
          n_nxt = n_r + 1'b1;
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r <= 1'b0;
      n_r <= '0;
    end else begin
      state_r <= state_nxt;
      ov_r <= ov_nxt;
      n_r <= n_nxt;
      pid_r <= pid_nxt;
      od_r <= od_nxt;
      fx_r <= fx_nxt;
      fe_r <= fe_nxt;
    end
  end
endmodule

// ===== src/sorted_timer_queue.sv =====
// sorted_timer_queue: sorted timer list held in a shifting cell row.
// Add/modify loads the request, unlinks the old entry, links the new one
// and registers the result; delete or an out-of-range id skips the link.
// A tick with nothing due gives a single result; one popping n timers gives
// one result per cycle while the sink does not stall. Requests are taken only
// while idle. Reset: synchronous active-low rst_n empties the list.
module sorted_timer_queue #(
  parameter int SLOTS     = stq_pkg::SLOTS_DEF,
  parameter int TIME_BITS = stq_pkg::TIME_BITS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  stq_in_if.sink    in_ch,
  stq_out_if.source out_ch
);
  import stq_pkg::*;
  stq_cmd_t cmd;
  stq_sts_t sts;
  logic wp, hc, qe, fe;
  logic [3:0] hid;
  logic [31:0] nx, fx;

  // datapath: cell row, pending bits, count
  stq_datapath #(.SLOTS(SLOTS), .TIME_BITS(TIME_BITS)) u_dp (
    .clk, .rst_n, .req(in_ch.data), .cmd, .sts,
    .was_pending(wp), .head_changed(hc), .head_id(hid),
    .next_expiry(nx), .queue_empty(qe),
    .fin_expiry(fx), .fin_empty(fe)
  );

  // controller: sequences unlink/link/pop and drives the result register
  stq_ctrl u_ctrl (
    .clk, .rst_n, .in_ch, .out_ch, .cmd, .sts,
    .was_pending(wp), .head_changed(hc), .head_id(hid),
    .next_expiry(nx), .queue_empty(qe),
    .fin_expiry(fx), .fin_empty(fe)
  );
endmodule

// ===== tb/sv/stq_tb_if.sv =====
`timescale 1ns / 100ps
// Channel interfaces come from the RTL (stq_if.sv); this file only carries
// the timer request record used by the scoreboard.
package stq_tb_pkg;
  import stq_pkg::*;

  typedef struct {
    mode_t       mode;
    logic [3:0]  timer_id;
    logic [31:0] time_value;
  } timer_req_t;
endpackage

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
module testbench;
  import stq_pkg::*;
  import stq_tb_pkg::*;

  // Shadow of the timer list: predicts every result a request causes.
  class timer_list_board;
    logic [31:0] expiry [16];
    bit          pending [16];
    logic [3:0]  order [$];
    out_req_t    awaited [$];
    int          errors;
    int          results_seen;
    int          expiries_seen;

    function void take_out(logic [3:0] id);
      for (int i = 0; i < order.size(); i++) begin
        if (order[i] == id) begin
          order.delete(i);
          break;
        end
      end
      pending[id] = 0;
    endfunction

    function void push_result(bit ev, logic [3:0] eid, bit wp, bit hc, bit lst);
      out_req_t r;
      r.expired_valid = ev;
      r.expired_id    = eid;
      r.was_pending   = wp;
      r.head_changed  = hc;
      r.next_expiry   = order.size() ? expiry[order[0]] : 32'd0;
      r.queue_empty   = (order.size() == 0);
      r.last          = lst;
      awaited.push_back(r);
    endfunction

    // Note an accepted request and queue what it should produce.
    function void note_request(timer_req_t q);
      logic [3:0] popped [$];
      bit wp;
      bit hc;
      int pos;
      if (q.mode == MODE_TICK) begin
        while (order.size() && popped.size() < MAX_OUT && expiry[order[0]] <= q.time_value) begin
          popped.push_back(order[0]);
          take_out(order[0]);
        end
        if (popped.size() == 0) push_result(0, 0, 0, 0, 1);
        foreach (popped[k]) push_result(1, popped[k], 0, 0, k == popped.size() - 1);
      end else begin
        wp = pending[q.timer_id];
        if (wp) take_out(q.timer_id);
        hc = 0;
        if (q.mode != MODE_DELETE) begin
          // ties keep arrival order: go after every equal expiry
          pos = 0;
          while (pos < order.size() && expiry[order[pos]] <= q.time_value) pos++;
          order.insert(pos, q.timer_id);
          expiry[q.timer_id]  = q.time_value;
          pending[q.timer_id] = 1;
          hc = (pos == 0);
        end
        push_result(0, 0, wp, hc, 1);
      end
    endfunction

    function void check_result(out_req_t got);
      out_req_t e;
      results_seen++;
      if (got.expired_valid) expiries_seen++;
      if (awaited.size() == 0) begin
        $error("unexpected result %p", got);
        errors++;
        return;
      end
      e = awaited.pop_front();
      if (got.expired_valid !== e.expired_valid) begin
        $error("expired_valid exp %0d got %0d", e.expired_valid, got.expired_valid); errors++;
      end
      if (got.expired_id !== e.expired_id) begin
        $error("expired_id exp %0d got %0d", e.expired_id, got.expired_id); errors++;
      end
      if (got.was_pending !== e.was_pending) begin
        $error("was_pending exp %0d got %0d", e.was_pending, got.was_pending); errors++;
      end
      if (got.head_changed !== e.head_changed) begin
        $error("head_changed exp %0d got %0d", e.head_changed, got.head_changed); errors++;
      end
      if (got.next_expiry !== e.next_expiry) begin
        $error("next_expiry exp %h got %h", e.next_expiry, got.next_expiry); errors++;
      end
      if (got.queue_empty !== e.queue_empty) begin
        $error("queue_empty exp %0d got %0d", e.queue_empty, got.queue_empty); errors++;
      end
      if (got.last !== e.last) begin
        $error("last exp %0d got %0d", e.last, got.last); errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  stq_in_if  in_ch ();
  stq_out_if out_ch ();

  sorted_timer_queue u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  timer_list_board board;
  int              requests_sent;

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  // Hand one request over; the board is told at the accepting edge.
  task automatic send_request(mode_t m, logic [3:0] id, logic [31:0] tv);
    timer_req_t q;
    int gap;
    gap = $urandom_range(0, 4);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    q.mode = m; q.timer_id = id; q.time_value = tv;
    in_ch.valid <= 1'b1;
    in_ch.data  <= '{mode: m, timer_id: id, time_value: tv};
    do @(posedge clk); while (!in_ch.ready);
    board.note_request(q);
    requests_sent++;
  endtask

  // Random expiry: mostly a small window so ticks find work, sometimes extreme.
  function automatic logic [31:0] pick_time();
    case ($urandom_range(0, 9))
      0:       return 32'hFFFF_FFFF - $urandom_range(0, 3);
      1:       return $urandom();
      2:       return $urandom_range(0, 3);
      default: return 32'h100 + $urandom_range(0, 255);
    endcase
  endfunction

  // Result side: random-length stalls, sampled at the edge.
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = $urandom_range(0, 4);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      board.check_result(out_ch.data);
    end
  end

  initial begin
    logic [31:0] now;
    int          guard;
    board = new();
    requests_sent = 0;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty tick, extremes, ties, re-add as modify, stray delete,
    // head changes, a full list of sixteen emptied by two ticks.
    send_request(MODE_TICK,   4'd0,  32'hFFFF_FFFF);
    send_request(MODE_DELETE, 4'd3,  32'd0);
    send_request(MODE_ADD,    4'd15, 32'hFFFF_FFFF);
    send_request(MODE_ADD,    4'd0,  32'd0);
    send_request(MODE_ADD,    4'd5,  32'd0);
    send_request(MODE_ADD,    4'd5,  32'h8000_0000);
    send_request(MODE_MODIFY, 4'd9,  32'h0000_1234);
    send_request(MODE_MODIFY, 4'd0,  32'h0000_1234);
    send_request(MODE_TICK,   4'd0,  32'd0);
    send_request(MODE_DELETE, 4'd15, 32'hFFFF_FFFF);
    send_request(MODE_TICK,   4'd7,  32'h0000_1234);
    send_request(MODE_TICK,   4'd0,  32'hFFFF_FFFF);
    for (int i = 0; i < 16; i++)
      send_request(MODE_ADD, i[3:0], (i % 3 == 0) ? 32'hFFFF_FFFF : 32'h7FFF_FFFF - i);
    send_request(MODE_TICK, 4'd0, 32'hFFFF_FFFE);
    send_request(MODE_TICK, 4'd0, 32'hFFFF_FFFF);

    // Random: adds dominate, ticks sweep a rising clock, now and then wide jumps.
    now = 32'h100;
    for (int n = 0; n < 120; n++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: send_request(MODE_ADD, 4'($urandom_range(0, 15)), pick_time());
        4:          send_request(MODE_DELETE, 4'($urandom_range(0, 15)), $urandom());
        5, 6:       send_request(MODE_MODIFY, 4'($urandom_range(0, 15)), pick_time());
        default: begin
          now = now + $urandom_range(0, 80);
          send_request(MODE_TICK, 4'($urandom_range(0, 15)),
                       ($urandom_range(0, 15) == 0) ? $urandom() : now);
        end
      endcase
    end
    in_ch.valid <= 1'b0;

    guard = 0;
    while (board.awaited.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (40) @(posedge clk);
    $display("%0d requests sent, %0d results checked, %0d of them expiries",
             requests_sent, board.results_seen, board.expiries_seen);
    if (board.errors == 0 && board.awaited.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      if (board.awaited.size() != 0) $error("%0d results never arrived", board.awaited.size());
      $display("testbench: FAIL");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #400000;
    $display("testbench: FAIL");
    $finish;
  end
endmodule
